// ===== sv/hbr_pkg.sv =====
`timescale 1ns / 1ps

package hbr_pkg;

    localparam int KEY_FIELDS  = 6;
    localparam int FLAG_COUNT  = 8;
    localparam int OUT_TOTAL_W = 24;
    localparam int CFG_INDEX_W = 2;

    localparam logic [7:0] KEY_NONE     = 8'd0;
    localparam logic [7:0] KEY_ROLLOVER = 8'd1;

    typedef enum logic [1:0] {
        CFG_DEVICE_KIND    = 2'd0,
        CFG_BLOCK_ACTIVE   = 2'd1,
        CFG_EVENTS_ENABLED = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        EV_KEY_DOWN   = 4'd0,
        EV_KEY_UP     = 4'd1,
        EV_MOD_DOWN   = 4'd2,
        EV_MOD_UP     = 4'd3,
        EV_MOVE       = 4'd4,
        EV_BTN_DOWN   = 4'd5,
        EV_BTN_UP     = 4'd6,
        EV_DISCONNECT = 4'd7,
        EV_TOTALS     = 4'd8
    } event_kind_t;

    typedef enum logic [2:0] {
        PH_READ       = 3'd0,
        PH_DISCONNECT = 3'd1,
        PH_KEY_DOWN   = 3'd2,
        PH_KEY_UP     = 3'd3,
        PH_FLAG       = 3'd4,
        PH_MOVE       = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DECIDE   = 3'd1,
        ST_KEY_DOWN = 3'd2,
        ST_KEY_UP   = 3'd3,
        ST_MOVE     = 3'd4,
        ST_FLAGS    = 3'd5,
        ST_FLUSH    = 3'd6
    } state_t;

    typedef struct packed {
        logic              command;
        logic              no_device;
        logic [7:0]        flag_bits;
        logic [7:0]        key_0;
        logic [7:0]        key_1;
        logic [7:0]        key_2;
        logic [7:0]        key_3;
        logic [7:0]        key_4;
        logic [7:0]        key_5;
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
    } item_t;

    typedef struct packed {
        event_kind_t        event_kind;
        logic [7:0]         event_value;
        logic signed [23:0] read_x;
        logic signed [23:0] read_y;
        logic               last_event;
    } result_t;

    typedef struct packed {
        logic   capture;
        logic   step;
        phase_t phase;
        logic   flush;
        logic   commit;
        logic   set_gone;
    } dp_cmd_t;

    typedef struct packed {
        logic command;
        logic no_device;
        logic device_kind;
        logic block_active;
        logic events_enabled;
        logic gone;
        logic hit;
        logic can_push;
        logic out_free;
        logic hold_valid;
    } dp_stat_t;

endpackage

// ===== sv/hbr_if.sv =====
`timescale 1ns / 1ps

interface hbr_item_if;
    logic              valid;
    logic              ready;
    logic              command;
    logic              no_device;
    logic [7:0]        flag_bits;
    logic [7:0]        key_0;
    logic [7:0]        key_1;
    logic [7:0]        key_2;
    logic [7:0]        key_3;
    logic [7:0]        key_4;
    logic [7:0]        key_5;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;

    modport source (
        output valid, command, no_device, flag_bits,
               key_0, key_1, key_2, key_3, key_4, key_5, move_x, move_y,
        input  ready
    );
    modport sink (
        input  valid, command, no_device, flag_bits,
               key_0, key_1, key_2, key_3, key_4, key_5, move_x, move_y,
        output ready
    );
endinterface

interface hbr_result_if;
    logic               valid;
    logic               ready;
    logic [3:0]         event_kind;
    logic [7:0]         event_value;
    logic signed [23:0] read_x;
    logic signed [23:0] read_y;
    logic               last_event;

    modport source (
        output valid, event_kind, event_value, read_x, read_y, last_event,
        input  ready
    );
    modport sink (
        input  valid, event_kind, event_value, read_x, read_y, last_event,
        output ready
    );
endinterface

// ===== sv/hid_boot_report_event_generator.sv =====
// HID boot report event generator. Each beat on item is either a keyboard or
// mouse boot report or a read-and-clear of the mouse totals; each produces
// zero to twenty event beats on result, the final one flagged by last_event.
// The block works on one beat at a time: a controller walks a shared compare
// unit over the key slots (key-down scan, then key-up scan) and over the eight
// flag bits, one step per cycle unless a step waits. A keyboard report runs
// both key scans and the flag scan, a mouse report a move step and the flag
// scan, and a read, disconnect or ignored report is settled in the decide
// state. A step that finds an event waits while the held event and the result
// register are full and result is not ready, so a slow sink lengthens the
// scan. Configuration must be written only between beats; writing 1 to
// block_active also clears the disconnect latch.
`timescale 1ns / 1ps

module hid_boot_report_event_generator #(
    parameter int KEY_SLOTS   = 6,
    parameter int TOTAL_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                            cfg_data,
    hbr_item_if.sink                        item,
    hbr_result_if.source                    result
);

    localparam int IDX_W = (KEY_SLOTS > hbr_pkg::FLAG_COUNT) ?
                           $clog2(KEY_SLOTS) : $clog2(hbr_pkg::FLAG_COUNT);

    hbr_pkg::item_t    item_beat;
    hbr_pkg::result_t  res_beat;
    hbr_pkg::dp_cmd_t  cmd;
    hbr_pkg::dp_stat_t st;
    logic [IDX_W-1:0]  idx;
    logic              res_valid;

    assign item_beat.command   = item.command;
    assign item_beat.no_device = item.no_device;
    assign item_beat.flag_bits = item.flag_bits;
    assign item_beat.key_0     = item.key_0;
    assign item_beat.key_1     = item.key_1;
    assign item_beat.key_2     = item.key_2;
    assign item_beat.key_3     = item.key_3;
    assign item_beat.key_4     = item.key_4;
    assign item_beat.key_5     = item.key_5;
    assign item_beat.move_x    = item.move_x;
    assign item_beat.move_y    = item.move_y;

    hbr_ctrl #(
        .KEY_SLOTS (KEY_SLOTS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .st         (st),
        .cmd        (cmd),
        .idx        (idx)
    );

    hbr_datapath #(
        .KEY_SLOTS   (KEY_SLOTS),
        .TOTAL_WIDTH (TOTAL_WIDTH),
        .IDX_W       (IDX_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_beat (item_beat),
        .cmd       (cmd),
        .idx       (idx),
        .st        (st),
        .res_valid (res_valid),
        .res_ready (result.ready),
        .res_beat  (res_beat)
    );

    assign result.valid       = res_valid;
    assign result.event_kind  = res_beat.event_kind;
    assign result.event_value = res_beat.event_value;
    assign result.read_x      = res_beat.read_x;
    assign result.read_y      = res_beat.read_y;
    assign result.last_event  = res_beat.last_event;

endmodule

// ===== sv/hbr_ctrl.sv =====
`timescale 1ns / 1ps

module hbr_ctrl #(
    parameter int KEY_SLOTS = 6,
    parameter int IDX_W     = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  hbr_pkg::dp_stat_t  st,
    output hbr_pkg::dp_cmd_t   cmd,
    output logic [IDX_W-1:0]   idx
);

    localparam logic [IDX_W-1:0] LAST_KEY  = IDX_W'(KEY_SLOTS - 1);
    localparam logic [IDX_W-1:0] LAST_FLAG = IDX_W'(hbr_pkg::FLAG_COUNT - 1);

    hbr_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             advance;

    assign idx     = idx_reg;
    assign advance = !st.hit || st.can_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hbr_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        item_ready   = 1'b0;
        cmd.capture  = 1'b0;
        cmd.step     = 1'b0;
        cmd.phase    = hbr_pkg::PH_READ;
        cmd.flush    = 1'b0;
        cmd.commit   = 1'b0;
        cmd.set_gone = 1'b0;
        unique case (state_reg)
            hbr_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = hbr_pkg::ST_DECIDE;
                end
            end
            hbr_pkg::ST_DECIDE:
            begin
                idx_next = '0;
                if (st.command)
                begin
                    cmd.step   = 1'b1;
                    cmd.phase  = hbr_pkg::PH_READ;
                    state_next = hbr_pkg::ST_FLUSH;
                end
                else if (st.no_device)
                begin
                    cmd.set_gone = 1'b1;
                    cmd.step     = st.events_enabled;
                    cmd.phase    = hbr_pkg::PH_DISCONNECT;
                    state_next   = hbr_pkg::ST_FLUSH;
                end
                else if (!st.block_active || st.gone)
                begin
                    state_next = hbr_pkg::ST_FLUSH;
                end
                else if (!st.events_enabled)
                begin
                    cmd.commit = 1'b1;
                    state_next = hbr_pkg::ST_FLUSH;
                end
                else if (st.device_kind)
                begin
                    state_next = hbr_pkg::ST_MOVE;
                end
                else
                begin
                    state_next = hbr_pkg::ST_KEY_DOWN;
                end
            end
            hbr_pkg::ST_KEY_DOWN:
            begin
                cmd.step  = 1'b1;
                cmd.phase = hbr_pkg::PH_KEY_DOWN;
                if (advance)
                begin
                    if (idx_reg == LAST_KEY)
                    begin
                        idx_next   = '0;
                        state_next = hbr_pkg::ST_KEY_UP;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            hbr_pkg::ST_KEY_UP:
            begin
                cmd.step  = 1'b1;
                cmd.phase = hbr_pkg::PH_KEY_UP;
                if (advance)
                begin
                    if (idx_reg == LAST_KEY)
                    begin
                        idx_next   = '0;
                        state_next = hbr_pkg::ST_FLAGS;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            hbr_pkg::ST_MOVE:
            begin
                cmd.step  = 1'b1;
                cmd.phase = hbr_pkg::PH_MOVE;
                if (advance)
                begin
                    idx_next   = '0;
                    state_next = hbr_pkg::ST_FLAGS;
                end
            end
            hbr_pkg::ST_FLAGS:
            begin
                cmd.step  = 1'b1;
                cmd.phase = hbr_pkg::PH_FLAG;
                if (advance)
                begin
                    if (idx_reg == LAST_FLAG)
                    begin
                        cmd.commit = 1'b1;
                        state_next = hbr_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            hbr_pkg::ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (!st.hold_valid || st.out_free)
                begin
                    state_next = hbr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hbr_pkg::ST_IDLE;
            end
        endcase
    end

    a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !cmd.commit)
        else $error("report committed twice");

    a_ignored_report: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hbr_pkg::ST_DECIDE && !st.command && !st.no_device &&
        (st.gone || !st.block_active) |=> state_reg == hbr_pkg::ST_FLUSH)
        else $error("ignored report was processed");

    a_hold_empty_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hbr_pkg::ST_DECIDE |-> !st.hold_valid)
        else $error("event left over from previous beat");

endmodule

// ===== sv/hbr_datapath.sv =====
`timescale 1ns / 1ps

module hbr_datapath #(
    parameter int KEY_SLOTS   = 6,
    parameter int TOTAL_WIDTH = 24,
    parameter int IDX_W       = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hbr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic                                cfg_data,
    input  hbr_pkg::item_t                      item_beat,
    input  hbr_pkg::dp_cmd_t                    cmd,
    input  logic [IDX_W-1:0]                    idx,
    output hbr_pkg::dp_stat_t                   st,
    output logic                                res_valid,
    input  logic                                res_ready,
    output hbr_pkg::result_t                    res_beat
);

    localparam int KI_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic signed [TOTAL_WIDTH-1:0] TOTAL_MAX = {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
    localparam logic signed [TOTAL_WIDTH-1:0] TOTAL_MIN = {1'b1, {(TOTAL_WIDTH-1){1'b0}}};

    logic [7:0] key_in   [hbr_pkg::KEY_FIELDS];
    logic [7:0] key_slot [KEY_SLOTS];

    logic                          device_kind_reg;
    logic                          block_active_reg;
    logic                          events_enabled_reg;
    logic                          gone_reg;

    logic                          command_reg;
    logic                          no_device_reg;
    logic [7:0]                    flags_reg;
    logic [7:0]                    keys_reg [KEY_SLOTS];
    logic signed [7:0]             dx_reg;
    logic signed [7:0]             dy_reg;

    logic [7:0]                    prev_keys_reg [KEY_SLOTS];
    logic [7:0]                    prev_flags_reg;
    logic signed [TOTAL_WIDTH-1:0] total_x_reg;
    logic signed [TOTAL_WIDTH-1:0] total_y_reg;

    logic                          hold_valid_reg;
    hbr_pkg::event_kind_t          hold_kind_reg;
    logic [7:0]                    hold_value_reg;
    logic signed [23:0]            hold_rx_reg;
    logic signed [23:0]            hold_ry_reg;

    logic                          out_valid_reg;
    hbr_pkg::event_kind_t          out_kind_reg;
    logic [7:0]                    out_value_reg;
    logic signed [23:0]            out_rx_reg;
    logic signed [23:0]            out_ry_reg;
    logic                          out_last_reg;

    logic                          hit;
    hbr_pkg::event_kind_t          ev_kind;
    logic [7:0]                    ev_value;
    logic signed [23:0]            ev_rx;
    logic signed [23:0]            ev_ry;
    logic [7:0]                    cur_key;
    logic [7:0]                    old_key;
    logic                          cur_in_prev;
    logic                          old_in_cur;
    logic [2:0]                    fidx;
    logic                          now_bit;
    logic                          was_bit;
    logic                          out_free;
    logic                          can_push;
    logic                          step_push;
    logic                          flush_push;
    logic                          move_out;
    logic                          read_push;

    function automatic logic signed [TOTAL_WIDTH-1:0] sat_add(
        input logic signed [TOTAL_WIDTH-1:0] acc,
        input logic signed [7:0]             delta
    );
        logic signed [TOTAL_WIDTH:0] sum;
        sum = {acc[TOTAL_WIDTH-1], acc} + (TOTAL_WIDTH+1)'(delta);
        if (sum[TOTAL_WIDTH] != sum[TOTAL_WIDTH-1])
            return sum[TOTAL_WIDTH] ? TOTAL_MIN : TOTAL_MAX;
        return sum[TOTAL_WIDTH-1:0];
    endfunction

    assign key_in[0] = item_beat.key_0;
    assign key_in[1] = item_beat.key_1;
    assign key_in[2] = item_beat.key_2;
    assign key_in[3] = item_beat.key_3;
    assign key_in[4] = item_beat.key_4;
    assign key_in[5] = item_beat.key_5;

    for (genvar gi = 0; gi < KEY_SLOTS; gi++)
    begin : g_slot
        if (gi < hbr_pkg::KEY_FIELDS)
        begin : g_used
            assign key_slot[gi] = key_in[gi];
        end
        else
        begin : g_empty
            assign key_slot[gi] = hbr_pkg::KEY_NONE;
        end
    end

    // configuration and disconnect latch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_kind_reg    <= 1'b0;
            block_active_reg   <= 1'b0;
            events_enabled_reg <= 1'b0;
            gone_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hbr_pkg::CFG_DEVICE_KIND:    device_kind_reg <= cfg_data;
                    hbr_pkg::CFG_BLOCK_ACTIVE:
                    begin
                        block_active_reg <= cfg_data;
                        if (cfg_data)
                            gone_reg <= 1'b0;
                    end
                    hbr_pkg::CFG_EVENTS_ENABLED: events_enabled_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.set_gone)
                gone_reg <= 1'b1;
        end
    end

    // captured beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg   <= item_beat.command;
            no_device_reg <= item_beat.no_device;
            flags_reg     <= item_beat.flag_bits;
            dx_reg        <= item_beat.move_x;
            dy_reg        <= item_beat.move_y;
            for (int i = 0; i < KEY_SLOTS; i++)
                keys_reg[i] <= key_slot[i];
        end
    end

    // event candidate for the current scan step
    assign cur_key = keys_reg[idx[KI_W-1:0]];
    assign old_key = prev_keys_reg[idx[KI_W-1:0]];
    assign fidx    = idx[2:0];
    assign now_bit = flags_reg[fidx];
    assign was_bit = prev_flags_reg[fidx];

    always_comb
    begin
        cur_in_prev = 1'b0;
        old_in_cur  = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++)
        begin
            if (prev_keys_reg[j] == cur_key)
                cur_in_prev = 1'b1;
            if (keys_reg[j] == old_key)
                old_in_cur = 1'b1;
        end
    end

    always_comb
    begin
        hit      = 1'b0;
        ev_kind  = hbr_pkg::EV_TOTALS;
        ev_value = '0;
        ev_rx    = '0;
        ev_ry    = '0;
        unique case (cmd.phase)
            hbr_pkg::PH_READ:
            begin
                hit     = 1'b1;
                ev_kind = hbr_pkg::EV_TOTALS;
                ev_rx   = hbr_pkg::OUT_TOTAL_W'(total_x_reg);
                ev_ry   = hbr_pkg::OUT_TOTAL_W'(total_y_reg);
            end
            hbr_pkg::PH_DISCONNECT:
            begin
                hit     = 1'b1;
                ev_kind = hbr_pkg::EV_DISCONNECT;
            end
            hbr_pkg::PH_KEY_DOWN:
            begin
                hit      = cur_key != hbr_pkg::KEY_NONE &&
                           cur_key != hbr_pkg::KEY_ROLLOVER && !cur_in_prev;
                ev_kind  = hbr_pkg::EV_KEY_DOWN;
                ev_value = cur_key;
            end
            hbr_pkg::PH_KEY_UP:
            begin
                hit      = old_key != hbr_pkg::KEY_NONE && !old_in_cur;
                ev_kind  = hbr_pkg::EV_KEY_UP;
                ev_value = old_key;
            end
            hbr_pkg::PH_FLAG:
            begin
                hit = now_bit ^ was_bit;
                if (device_kind_reg)
                begin
                    ev_kind  = now_bit ? hbr_pkg::EV_BTN_DOWN : hbr_pkg::EV_BTN_UP;
                    ev_value = 8'(fidx);
                end
                else
                begin
                    ev_kind  = now_bit ? hbr_pkg::EV_MOD_DOWN : hbr_pkg::EV_MOD_UP;
                    ev_value = 8'd1 << fidx;
                end
            end
            hbr_pkg::PH_MOVE:
            begin
                hit     = dx_reg != '0 || dy_reg != '0;
                ev_kind = hbr_pkg::EV_MOVE;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    // one event is held back so that the final one can carry last_event
    assign out_free   = !out_valid_reg || res_ready;
    assign can_push   = !hold_valid_reg || out_free;
    assign step_push  = cmd.step && hit && can_push;
    assign flush_push = cmd.flush && hold_valid_reg && out_free;
    assign move_out   = (step_push && hold_valid_reg) || flush_push;
    assign read_push  = step_push && cmd.phase == hbr_pkg::PH_READ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (step_push)
                hold_valid_reg <= 1'b1;
            else if (flush_push)
                hold_valid_reg <= 1'b0;
            if (move_out)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_push)
        begin
            hold_kind_reg  <= ev_kind;
            hold_value_reg <= ev_value;
            hold_rx_reg    <= ev_rx;
            hold_ry_reg    <= ev_ry;
        end
        if (move_out)
        begin
            out_kind_reg  <= hold_kind_reg;
            out_value_reg <= hold_value_reg;
            out_rx_reg    <= hold_rx_reg;
            out_ry_reg    <= hold_ry_reg;
            out_last_reg  <= flush_push;
        end
    end

    // stored report and mouse totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_flags_reg <= '0;
            total_x_reg    <= '0;
            total_y_reg    <= '0;
            for (int i = 0; i < KEY_SLOTS; i++)
                prev_keys_reg[i] <= hbr_pkg::KEY_NONE;
        end
        else if (read_push)
        begin
            total_x_reg <= '0;
            total_y_reg <= '0;
        end
        else if (cmd.commit)
        begin
            prev_flags_reg <= flags_reg;
            for (int i = 0; i < KEY_SLOTS; i++)
                prev_keys_reg[i] <= keys_reg[i];
            if (device_kind_reg)
            begin
                total_x_reg <= sat_add(total_x_reg, dx_reg);
                total_y_reg <= sat_add(total_y_reg, dy_reg);
            end
        end
    end

    assign st.command        = command_reg;
    assign st.no_device      = no_device_reg;
    assign st.device_kind    = device_kind_reg;
    assign st.block_active   = block_active_reg;
    assign st.events_enabled = events_enabled_reg;
    assign st.gone           = gone_reg;
    assign st.hit            = hit;
    assign st.can_push       = can_push;
    assign st.out_free       = out_free;
    assign st.hold_valid     = hold_valid_reg;

    assign res_valid            = out_valid_reg;
    assign res_beat.event_kind  = out_kind_reg;
    assign res_beat.event_value = out_value_reg;
    assign res_beat.read_x      = out_rx_reg;
    assign res_beat.read_y      = out_ry_reg;
    assign res_beat.last_event  = out_last_reg;

    a_totals_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg != hbr_pkg::EV_TOTALS |->
        out_rx_reg == '0 && out_ry_reg == '0)
        else $error("totals on a non-read event");

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        read_push |=> total_x_reg == '0 && total_y_reg == '0)
        else $error("totals not cleared after read");

    a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        flush_push |=> !hold_valid_reg && out_valid_reg && out_last_reg)
        else $error("final event not marked last");

endmodule
